// ----- hdl/cms_pkg.sv -----
package cms_pkg;

   // Default sizes
   localparam int ROWS_DEF          = 4;
   localparam int ROW_DEPTH_DEF     = 1024;
   localparam int COUNT_BITS_DEF    = 32;
   localparam int MAX_KEY_BYTES_DEF = 64;
   localparam int MAX_ROWS          = 4;

   // Murmur constants
   localparam logic [63:0] MM_MUL   = 64'hc6a4_a793_5bd1_e995;
   localparam int          MM_SHIFT = 47;

   // Field and register widths
   localparam int KEY_LEN_W  = 7;
   localparam int ROW_LEN_W  = 11;
   localparam int CSR_W      = 64;
   localparam int CSR_IDX_W  = 3;
   localparam int EST_W      = 32;

   localparam logic [ROW_LEN_W-1:0] ROW_LEN_RESET = 11'd1024;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_ROW_LENGTH = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SEED_ROW0  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SEED_ROW1  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SEED_ROW2  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_SEED_ROW3  = 3'd4;

   // Item kinds
   localparam logic KIND_ADD   = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   typedef logic [MAX_ROWS-1:0][63:0] seed_array_type;

   // One finished key, handed from hashing to counter update
   typedef struct packed {
      logic                      kind;
      logic [MAX_ROWS-1:0][63:0] hash;
   } hash_entry_type;

   typedef enum logic [3:0] {
      F_IDLE, F_INIT, F_DISP, F_K1, F_K2, F_ROW, F_END, F_FIN, F_PUSH
   } front_state_type;

   typedef enum logic [2:0] {
      B_CLEAR, B_IDLE, B_DIV, B_RD, B_UPD, B_OUT
   } back_state_type;

endpackage

// ----- hdl/cms_ram.sv -----
module cms_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end

endmodule

// ----- hdl/cms_queue.sv -----
module cms_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNTW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PW-1:0]    wr_ff, wr_in, rd_ff, rd_in;
   logic [CNTW-1:0]  cnt_ff, cnt_in;

   assign full     = (cnt_ff == CNTW'(DEPTH));
   assign empty    = (cnt_ff == '0);
   assign pop_data = slot_ff[rd_ff];

   // Pointer and fill count
   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push && !full) begin
         wr_in = (wr_ff == PW'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop && !empty) begin
         rd_in = (rd_ff == PW'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if ((push && !full) && !(pop && !empty)) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (!(push && !full) && (pop && !empty)) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push && !full) begin
         slot_ff[wr_ff] <= push_data;
      end
   end

endmodule

// ----- hdl/cms_front.sv -----
module cms_front #(
   parameter int ROWS          = cms_pkg::ROWS_DEF,
   parameter int MAX_KEY_BYTES = cms_pkg::MAX_KEY_BYTES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          hold,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic                          req_kind,
   input  logic [63:0]                   req_chunk,
   input  logic [cms_pkg::KEY_LEN_W-1:0] req_key_length,
   input  logic                          req_last,
   input  cms_pkg::seed_array_type       seeds,
   output logic                          q_push,
   output cms_pkg::hash_entry_type       q_data,
   input  logic                          q_full
);

   localparam int BS_W  = $clog2(MAX_KEY_BYTES + 1);
   localparam int LEN_W = (BS_W > cms_pkg::KEY_LEN_W) ? BS_W : cms_pkg::KEY_LEN_W;
   localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;

   cms_pkg::front_state_type state_ff, state_in;
   logic [BS_W-1:0]          bs_ff, bs_in, len_ff, len_in;
   logic                     kind_ff, kind_in, last_ff, last_in;
   logic [63:0]              chunk_ff, chunk_in, k_ff, k_in, acc_ff, acc_in;
   logic [ROWS-1:0][63:0]    h_ff, h_in;
   logic [RW-1:0]            row_ff, row_in;
   logic [1:0]               ph_ff, ph_in;

   logic [LEN_W-1:0] len_ext;
   logic [BS_W-1:0]  len_sat, rem;
   logic [63:0]      tail_mask, mul_a, h_cur;
   logic [31:0]      a32, b32;
   logic [63:0]      part;
   logic             mul_state, mul_done, last_row;

   // Key length clamp
   assign len_ext = LEN_W'(req_key_length);
   assign len_sat = (len_ext > LEN_W'(MAX_KEY_BYTES)) ? BS_W'(MAX_KEY_BYTES) : BS_W'(len_ext);

   // Bytes still owed by this key
   assign rem = (len_ff > bs_ff) ? (len_ff - bs_ff) : '0;

   always_comb begin
      tail_mask = '0;
      for (int b = 0; b < 8; b++) begin
         if (BS_W'(b) < rem) begin
            tail_mask[8*b +: 8] = 8'hff;
         end
      end
   end

   assign h_cur    = h_ff[row_ff];
   assign last_row = (row_ff == RW'(ROWS - 1));

   // Multiplier operand, stable for the whole product
   always_comb begin
      case (state_ff)
         cms_pkg::F_INIT: mul_a = 64'(len_ff);
         cms_pkg::F_K1:   mul_a = chunk_ff;
         cms_pkg::F_K2:   mul_a = k_ff ^ (k_ff >> cms_pkg::MM_SHIFT);
         cms_pkg::F_ROW:  mul_a = h_cur ^ k_ff;
         default:         mul_a = h_cur ^ (h_cur >> cms_pkg::MM_SHIFT);
      endcase
   end

   // Truncated 64x64 product by MM_MUL: three 32x32 partials, one per cycle
   assign mul_state = (state_ff == cms_pkg::F_INIT) || (state_ff == cms_pkg::F_K1) ||
                      (state_ff == cms_pkg::F_K2) || (state_ff == cms_pkg::F_ROW) ||
                      (state_ff == cms_pkg::F_FIN);
   assign a32      = (ph_ff == 2'd2) ? mul_a[63:32] : mul_a[31:0];
   assign b32      = (ph_ff == 2'd1) ? cms_pkg::MM_MUL[63:32] : cms_pkg::MM_MUL[31:0];
   assign part     = 64'(a32) * 64'(b32);
   assign acc_in   = (ph_ff == 2'd0) ? part : acc_ff + {part[31:0], 32'd0};
   assign mul_done = mul_state && (ph_ff == 2'd2);
   assign ph_in    = (mul_state && !mul_done) ? ph_ff + 2'd1 : 2'd0;

   // Finished hashes for the queue
   always_comb begin
      q_data      = '0;
      q_data.kind = kind_ff;
      for (int r = 0; r < ROWS; r++) begin
         q_data.hash[r] = h_ff[r] ^ (h_ff[r] >> cms_pkg::MM_SHIFT);
      end
   end

   assign req_tready = (state_ff == cms_pkg::F_IDLE) && !hold;
   assign q_push     = (state_ff == cms_pkg::F_PUSH) && !q_full;

   // Sequencer
   always_comb begin
      state_in = state_ff;
      bs_in    = bs_ff;
      len_in   = len_ff;
      kind_in  = kind_ff;
      last_in  = last_ff;
      chunk_in = chunk_ff;
      k_in     = k_ff;
      h_in     = h_ff;
      row_in   = row_ff;
      unique case (state_ff)
         cms_pkg::F_IDLE: begin
            if (req_tvalid && req_tready) begin
               kind_in  = req_kind;
               chunk_in = req_chunk;
               len_in   = len_sat;
               last_in  = req_last;
               state_in = (bs_ff == '0) ? cms_pkg::F_INIT : cms_pkg::F_DISP;
            end
         end
         cms_pkg::F_INIT: begin
            if (mul_done) begin
               for (int r = 0; r < ROWS; r++) begin
                  h_in[r] = seeds[r] ^ acc_in;
               end
               state_in = cms_pkg::F_DISP;
            end
         end
         cms_pkg::F_DISP: begin
            row_in = '0;
            if (last_ff) begin
               bs_in = '0;
            end else if (rem >= BS_W'(8)) begin
               bs_in = bs_ff + BS_W'(8);
            end else begin
               bs_in = bs_ff + rem;
            end
            if (rem >= BS_W'(8)) begin
               state_in = cms_pkg::F_K1;
            end else if (rem != '0) begin
               k_in     = chunk_ff & tail_mask;
               state_in = cms_pkg::F_ROW;
            end else begin
               state_in = cms_pkg::F_END;
            end
         end
         cms_pkg::F_K1: begin
            if (mul_done) begin
               k_in     = acc_in;
               state_in = cms_pkg::F_K2;
            end
         end
         cms_pkg::F_K2: begin
            if (mul_done) begin
               k_in     = acc_in;
               state_in = cms_pkg::F_ROW;
            end
         end
         cms_pkg::F_ROW: begin
            if (mul_done) begin
               h_in[row_ff] = acc_in;
               if (last_row) begin
                  state_in = cms_pkg::F_END;
               end else begin
                  row_in = row_ff + 1'b1;
               end
            end
         end
         cms_pkg::F_END: begin
            row_in   = '0;
            state_in = last_ff ? cms_pkg::F_FIN : cms_pkg::F_IDLE;
         end
         cms_pkg::F_FIN: begin
            if (mul_done) begin
               h_in[row_ff] = acc_in;
               if (last_row) begin
                  state_in = cms_pkg::F_PUSH;
               end else begin
                  row_in = row_ff + 1'b1;
               end
            end
         end
         cms_pkg::F_PUSH: begin
            if (!q_full) begin
               state_in = cms_pkg::F_IDLE;
            end
         end
         default: state_in = cms_pkg::F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cms_pkg::F_IDLE;
         bs_ff    <= '0;
         ph_ff    <= '0;
         row_ff   <= '0;
      end else begin
         state_ff <= state_in;
         bs_ff    <= bs_in;
         ph_ff    <= ph_in;
         row_ff   <= row_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff   <= len_in;
      kind_ff  <= kind_in;
      last_ff  <= last_in;
      chunk_ff <= chunk_in;
      k_ff     <= k_in;
      h_ff     <= h_in;
      acc_ff   <= acc_in;
   end

endmodule

// ----- hdl/cms_back.sv -----
module cms_back #(
   parameter int ROWS       = cms_pkg::ROWS_DEF,
   parameter int ROW_DEPTH  = cms_pkg::ROW_DEPTH_DEF,
   parameter int COUNT_BITS = cms_pkg::COUNT_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [cms_pkg::ROW_LEN_W-1:0] row_length,
   input  logic                          q_empty,
   output logic                          q_pop,
   input  cms_pkg::hash_entry_type       q_data,
   output logic                          clearing,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [cms_pkg::EST_W-1:0]     rsp_estimate
);

   localparam int CW   = $clog2(ROW_DEPTH);
   localparam int MW   = $clog2(ROW_DEPTH + 1);
   localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int AW   = RW + CW;
   localparam int CMPW = (MW > cms_pkg::ROW_LEN_W) ? MW : cms_pkg::ROW_LEN_W;
   localparam int EW   = (COUNT_BITS > cms_pkg::EST_W) ? COUNT_BITS : cms_pkg::EST_W;

   cms_pkg::back_state_type state_ff, state_in;
   cms_pkg::hash_entry_type entry_ff, entry_in;
   logic [RW-1:0]           row_ff, row_in;
   logic [63:0]             q_ff, q_in;
   logic [MW-1:0]           r_ff, r_in, m_ff, m_in, r_step;
   logic [3:0]              cnt_ff, cnt_in;
   logic [COUNT_BITS-1:0]   best_ff, best_in;
   logic [AW-1:0]           clr_ff, clr_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [cms_pkg::EST_W-1:0] rsp_data_ff, rsp_data_in;

   logic [CMPW-1:0]       rl_ext;
   logic [MW-1:0]         m_eff;
   logic                  ram_we;
   logic [AW-1:0]         ram_waddr, ram_raddr;
   logic [COUNT_BITS-1:0] ram_wdata, rd_count;
   logic [COUNT_BITS-1:0] ram_rdata_w;
   logic [EW-1:0]         best_ext;
   logic [cms_pkg::EST_W-1:0] est;
   logic                  last_row;

   // Modulus in use
   assign rl_ext = CMPW'(row_length);
   assign m_eff  = (rl_ext == '0) ? MW'(1) :
                   (rl_ext > CMPW'(ROW_DEPTH)) ? MW'(ROW_DEPTH) : MW'(rl_ext);

   // Remainder, four dividend bits a cycle
   always_comb begin
      logic [MW:0]   t;
      logic [MW-1:0] rr;
      rr = r_ff;
      for (int i = 0; i < 4; i++) begin
         t = {rr, q_ff[63-i]};
         if (t >= {1'b0, m_ff}) begin
            t = t - {1'b0, m_ff};
         end
         rr = t[MW-1:0];
      end
      r_step = rr;
   end

   assign ram_raddr = {row_ff, r_ff[CW-1:0]};
   assign rd_count  = ram_rdata_w;
   assign last_row  = (row_ff == RW'(ROWS - 1));
   assign clearing  = (state_ff == cms_pkg::B_CLEAR);
   assign q_pop     = (state_ff == cms_pkg::B_IDLE) && !q_empty;

   // Estimate clamp to the port width
   assign best_ext = EW'(best_ff);
   assign est = (best_ext > EW'(32'hffff_ffff)) ? 32'hffff_ffff : best_ext[cms_pkg::EST_W-1:0];

   cms_ram #(
      .WIDTH (COUNT_BITS),
      .DEPTH (1 << AW)
   ) u_counters (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata_w)
   );

   // Row sequencer
   always_comb begin
      state_in     = state_ff;
      entry_in     = entry_ff;
      row_in       = row_ff;
      q_in         = q_ff;
      r_in         = r_ff;
      m_in         = m_ff;
      cnt_in       = cnt_ff;
      best_in      = best_ff;
      clr_in       = clr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      ram_we       = 1'b0;
      ram_waddr    = ram_raddr;
      ram_wdata    = rd_count + 1'b1;
      unique case (state_ff)
         cms_pkg::B_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            ram_wdata = '0;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == '1) begin
               state_in = cms_pkg::B_IDLE;
            end
         end
         cms_pkg::B_IDLE: begin
            if (!q_empty) begin
               entry_in = q_data;
               row_in   = '0;
               m_in     = m_eff;
               q_in     = q_data.hash[0];
               r_in     = '0;
               cnt_in   = '0;
               best_in  = '1;
               state_in = cms_pkg::B_DIV;
            end
         end
         cms_pkg::B_DIV: begin
            r_in   = r_step;
            q_in   = {q_ff[59:0], 4'd0};
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'd15) begin
               state_in = cms_pkg::B_RD;
            end
         end
         cms_pkg::B_RD: begin
            state_in = cms_pkg::B_UPD;
         end
         cms_pkg::B_UPD: begin
            if (entry_ff.kind == cms_pkg::KIND_ADD) begin
               ram_we = (rd_count != {COUNT_BITS{1'b1}});
            end else if (rd_count < best_ff) begin
               best_in = rd_count;
            end
            if (last_row) begin
               state_in = (entry_ff.kind == cms_pkg::KIND_QUERY) ? cms_pkg::B_OUT
                                                                 : cms_pkg::B_IDLE;
            end else begin
               row_in   = row_ff + 1'b1;
               q_in     = entry_ff.hash[2'(row_ff + 1'b1)];
               r_in     = '0;
               cnt_in   = '0;
               state_in = cms_pkg::B_DIV;
            end
         end
         cms_pkg::B_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = est;
               state_in     = cms_pkg::B_IDLE;
            end
         end
         default: state_in = cms_pkg::B_IDLE;
      endcase
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_estimate = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cms_pkg::B_CLEAR;
         clr_ff       <= '0;
         row_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         row_ff       <= row_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff    <= entry_in;
      q_ff        <= q_in;
      r_ff        <= r_in;
      m_ff        <= m_in;
      best_ff     <= best_in;
      rsp_data_ff <= rsp_data_in;
   end

`ifndef SYNTHESIS
   a_no_pop_while_clearing: assert property (@(posedge clock) disable iff (reset)
      clearing |-> !q_pop) else $error("queue popped during clearing pass");
   a_query_never_writes: assert property (@(posedge clock) disable iff (reset)
      (state_ff == cms_pkg::B_UPD && entry_ff.kind == cms_pkg::KIND_QUERY) |-> !ram_we)
      else $error("counter written by a query");
   a_write_only_in_update: assert property (@(posedge clock) disable iff (reset)
      (ram_we && !clearing) |-> (state_ff == cms_pkg::B_UPD))
      else $error("counter write outside update step");
   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == cms_pkg::B_OUT && !rsp_valid_ff) |=> rsp_valid_ff)
      else $error("estimate not loaded into output register");
`endif

endmodule

// ----- hdl/count_min_sketch_top.sv -----
// Channel   Dir  Ports                       Contents
// req       in   req_tvalid/tready/tdata     tdata: chunk[63:0], key_length[70:64]
//                req_tlast, req_tuser        tlast: last chunk, tuser: kind
// rsp       out  rsp_tvalid/tready/tdata     tdata: estimate[31:0]
// csr       in   csr_wen/index/wdata         0 row_length, 1..4 seed_row0..3
//
// Each 64-bit multiply is built from 32x32 partials on the shared multiplier: a full
// chunk takes two multiplies for the key mix and one per row, a key's first chunk
// adds one for the seed step, and a last chunk adds one per row to finish plus the
// queue push. Counter update runs behind a 2-entry queue; each row takes a remainder
// at four dividend bits a cycle, then a RAM read and, for an add, a saturating write.
// After reset all 2^(ceil(log2(ROWS))+ceil(log2(ROW_DEPTH))) counter words are cleared,
// with req_tready low. A stalled rsp holds one estimate while work goes on.
module count_min_sketch_top #(
   parameter int ROWS          = cms_pkg::ROWS_DEF,
   parameter int ROW_DEPTH     = cms_pkg::ROW_DEPTH_DEF,
   parameter int COUNT_BITS    = cms_pkg::COUNT_BITS_DEF,
   parameter int MAX_KEY_BYTES = cms_pkg::MAX_KEY_BYTES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [71:0]                   req_tdata,  // chunk, key_length, pad
   input  logic                          req_tlast,
   input  logic                          req_tuser,  // kind
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [31:0]                   rsp_tdata,  // estimate
   input  logic                          csr_wen,
   input  logic [cms_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [cms_pkg::CSR_W-1:0]     csr_wdata
);

   logic [cms_pkg::ROW_LEN_W-1:0] row_length_ff;
   cms_pkg::seed_array_type       seeds_ff;
   cms_pkg::hash_entry_type       push_data, pop_data;
   logic                          q_push, q_pop, q_full, q_empty, clearing;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         row_length_ff <= cms_pkg::ROW_LEN_RESET;
         seeds_ff[0]   <= 64'd0;
         seeds_ff[1]   <= 64'd1;
         seeds_ff[2]   <= 64'd2;
         seeds_ff[3]   <= 64'd3;
      end else if (csr_wen) begin
         unique case (csr_index)
            cms_pkg::REG_ROW_LENGTH: row_length_ff <= csr_wdata[cms_pkg::ROW_LEN_W-1:0];
            cms_pkg::REG_SEED_ROW0:  seeds_ff[0] <= csr_wdata;
            cms_pkg::REG_SEED_ROW1:  seeds_ff[1] <= csr_wdata;
            cms_pkg::REG_SEED_ROW2:  seeds_ff[2] <= csr_wdata;
            cms_pkg::REG_SEED_ROW3:  seeds_ff[3] <= csr_wdata;
            default: ;
         endcase
      end
   end

   cms_front #(
      .ROWS          (ROWS),
      .MAX_KEY_BYTES (MAX_KEY_BYTES)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .hold           (clearing),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_kind       (req_tuser),
      .req_chunk      (req_tdata[63:0]),
      .req_key_length (req_tdata[70:64]),
      .req_last       (req_tlast),
      .seeds          (seeds_ff),
      .q_push         (q_push),
      .q_data         (push_data),
      .q_full         (q_full)
   );

   cms_queue #(
      .WIDTH ($bits(cms_pkg::hash_entry_type)),
      .DEPTH (2)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (push_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (pop_data),
      .empty     (q_empty)
   );

   cms_back #(
      .ROWS       (ROWS),
      .ROW_DEPTH  (ROW_DEPTH),
      .COUNT_BITS (COUNT_BITS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .row_length   (row_length_ff),
      .q_empty      (q_empty),
      .q_pop        (q_pop),
      .q_data       (pop_data),
      .clearing     (clearing),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_estimate (rsp_tdata)
   );

endmodule
